/* design/scroll_page_redraw_tracker_assert.svh */
// ----------------------------------------------------------------------------
// Scroll page redraw tracker assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SCROLL_PAGE_REDRAW_TRACKER_ASSERT_SVH
`define SCROLL_PAGE_REDRAW_TRACKER_ASSERT_SVH

// same-cycle implication
`define SPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/spr_pkg.sv */
// ----------------------------------------------------------------------------
// Scroll page redraw tracker package
// Field widths, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int POS_W    = 32;
    localparam int SPAN_W   = 16;
    localparam int WLEN_W   = 31;
    localparam int FRAME_W  = 16;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int PAGE_COUNT = 2;

    localparam logic [KIND_W-1:0] KIND_CLAMP      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MARK       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLIP       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INVALIDATE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BEGIN      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SPAN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SPAN = 1'd1;

    localparam logic [SPAN_W-1:0] VIEW_SPAN_RESET = 16'd320;
    localparam logic [SPAN_W-1:0] PAGE_SPAN_RESET = 16'd640;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [POS_W-1:0]   position;
        logic signed [POS_W-1:0]   end_position;
        logic [WLEN_W-1:0]         world_length;
        logic [FRAME_W-1:0]        frame_count;
    } req_t;

    typedef struct packed {
        logic                      need_draw;
        logic signed [POS_W-1:0]   span_from;
        logic signed [POS_W-1:0]   span_to;
        logic [FRAME_W-1:0]        elapsed_frames;
    } rsp_t;

endpackage

/* design/spr_req_if.sv */
// ----------------------------------------------------------------------------
// Scroll page redraw tracker request channel
// Valid/ready channel carrying one command request.
// ----------------------------------------------------------------------------
interface spr_req_if;
    import spr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] end_position;
    logic [WLEN_W-1:0]       world_length;
    logic [FRAME_W-1:0]      frame_count;

    modport source (output valid, kind, position, end_position, world_length, frame_count,
                    input ready);
    modport sink (input valid, kind, position, end_position, world_length, frame_count,
                  output ready);
endinterface

/* design/spr_rsp_if.sv */
// ----------------------------------------------------------------------------
// Scroll page redraw tracker response channel
// Valid/ready channel carrying one command result.
// ----------------------------------------------------------------------------
interface spr_rsp_if;
    import spr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    need_draw;
    logic signed [POS_W-1:0] span_from;
    logic signed [POS_W-1:0] span_to;
    logic [FRAME_W-1:0]      elapsed_frames;

    modport source (output valid, need_draw, span_from, span_to, elapsed_frames,
                    input ready);
    modport sink (input valid, need_draw, span_from, span_to, elapsed_frames,
                  output ready);
endinterface

/* design/scroll_page_redraw_tracker.sv */
// ----------------------------------------------------------------------------
// Scroll page redraw tracker
// A request is held in the input register, evaluated against the camera,
// frame and two-page drawn-span state once the result register can advance,
// and lands in the result register as the state updates, so back-to-back
// requests always see the effect of the one before. Throughput is one request
// per cycle while the response side keeps taking results; a stalled result
// register holds the input register and then the request channel.
// ----------------------------------------------------------------------------
module scroll_page_redraw_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spr_pkg::SPAN_W-1:0]     cfg_data,
    spr_req_if.sink                        req,
    spr_rsp_if.source                      rsp
);
    import spr_pkg::*;

    `include "scroll_page_redraw_tracker_assert.svh"

    logic [SPAN_W-1:0]       view_span_reg;
    logic [SPAN_W-1:0]       page_span_reg;
    logic signed [POS_W-1:0] camera_reg;
    logic signed [POS_W-1:0] camera_next;
    logic                    back_page_reg;
    logic                    back_page_next;
    logic [FRAME_W-1:0]      seen_frame_reg;
    logic [FRAME_W-1:0]      seen_frame_next;
    logic signed [POS_W-1:0] drawn_start_reg [PAGE_COUNT];
    logic signed [POS_W-1:0] drawn_end_reg   [PAGE_COUNT];
    logic signed [POS_W-1:0] page_start_next;
    logic signed [POS_W-1:0] page_end_next;
    logic                    page_write;
    logic                    pages_clear;

    logic                    s1_valid_reg;
    req_t                    s1_reg;
    logic                    rsp_valid_reg;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;
    logic                    advance;
    logic                    fire;

    logic signed [POS_W-1:0] ds;
    logic signed [POS_W-1:0] de;
    logic signed [POS_W-1:0] view_end;
    logic signed [POS_W-1:0] max_pos;
    logic signed [POS_W-1:0] span_ext;
    logic signed [POS_W-1:0] merge_start;
    logic signed [POS_W-1:0] merge_end;
    logic signed [POS_W-1:0] merge_len;
    logic [FRAME_W-1:0]      frame_diff;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.need_draw      = rsp_reg.need_draw;
    assign rsp.span_from      = rsp_reg.span_from;
    assign rsp.span_to        = rsp_reg.span_to;
    assign rsp.elapsed_frames = rsp_reg.elapsed_frames;

    always_comb
    begin
        ds          = drawn_start_reg[back_page_reg];
        de          = drawn_end_reg[back_page_reg];
        view_end    = camera_reg + $signed({16'd0, view_span_reg});
        span_ext    = $signed({16'd0, page_span_reg});
        max_pos     = $signed({1'b0, s1_reg.world_length}) - $signed({16'd0, view_span_reg});
        merge_start = (s1_reg.position < ds) ? s1_reg.position : ds;
        merge_end   = (de < s1_reg.end_position) ? s1_reg.end_position : de;
        merge_len   = merge_end - merge_start;
        frame_diff  = s1_reg.frame_count - seen_frame_reg;

        camera_next     = camera_reg;
        back_page_next  = back_page_reg;
        seen_frame_next = seen_frame_reg;
        page_start_next = ds;
        page_end_next   = de;
        page_write      = 1'b0;
        pages_clear     = 1'b0;
        rsp_next        = '0;

        case (s1_reg.kind)
            KIND_CLAMP:
            begin
                if (max_pos[POS_W-1])
                begin
                    max_pos = '0;
                end
                camera_next = s1_reg.position[POS_W-1] ? '0 : s1_reg.position;
                if (max_pos < camera_next)
                begin
                    camera_next = max_pos;
                end
            end
            KIND_QUERY:
            begin
                if (!(ds < de))
                begin
                    rsp_next.need_draw = 1'b1;
                    rsp_next.span_from = camera_reg;
                    rsp_next.span_to   = view_end;
                end
                else if (!(camera_reg < ds) && !(de < view_end))
                begin
                    rsp_next.need_draw = 1'b0;
                end
                else if (!(camera_reg < de) || !(ds < view_end))
                begin
                    rsp_next.need_draw = 1'b1;
                    rsp_next.span_from = camera_reg;
                    rsp_next.span_to   = view_end;
                end
                else if (de < view_end)
                begin
                    rsp_next.need_draw = 1'b1;
                    rsp_next.span_from = de;
                    rsp_next.span_to   = view_end;
                end
                else
                begin
                    rsp_next.need_draw = 1'b1;
                    rsp_next.span_from = camera_reg;
                    rsp_next.span_to   = ds;
                end
            end
            KIND_MARK:
            begin
                page_write = 1'b1;
                if (!(ds < de) || (de < s1_reg.position) || (s1_reg.end_position < ds))
                begin
                    page_start_next = s1_reg.position;
                    page_end_next   = s1_reg.end_position;
                end
                else
                begin
                    page_start_next = (span_ext < merge_len) ? merge_end - span_ext
                                                             : merge_start;
                    page_end_next   = merge_end;
                end
            end
            KIND_FLIP:
            begin
                rsp_next.elapsed_frames = (frame_diff == '0) ? FRAME_W'(1) : frame_diff;
                seen_frame_next         = s1_reg.frame_count;
                back_page_next          = !back_page_reg;
            end
            KIND_INVALIDATE:
            begin
                pages_clear = 1'b1;
            end
            KIND_BEGIN:
            begin
                pages_clear     = 1'b1;
                back_page_next  = 1'b1;
                camera_next     = '0;
                seen_frame_next = s1_reg.frame_count;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_span_reg <= VIEW_SPAN_RESET;
            page_span_reg <= PAGE_SPAN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VIEW_SPAN: view_span_reg <= cfg_data;
                CFG_PAGE_SPAN: page_span_reg <= cfg_data;
                default:       view_span_reg <= view_span_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_reg     <= '0;
            back_page_reg  <= 1'b1;
            seen_frame_reg <= '0;
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                drawn_start_reg[i] <= '0;
                drawn_end_reg[i]   <= '0;
            end
        end
        else if (fire)
        begin
            camera_reg     <= camera_next;
            back_page_reg  <= back_page_next;
            seen_frame_reg <= seen_frame_next;
            if (pages_clear)
            begin
                for (int i = 0; i < PAGE_COUNT; i++)
                begin
                    drawn_start_reg[i] <= '0;
                    drawn_end_reg[i]   <= '0;
                end
            end
            else if (page_write)
            begin
                drawn_start_reg[back_page_reg] <= page_start_next;
                drawn_end_reg[back_page_reg]   <= page_end_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg.kind         <= req.kind;
            s1_reg.position     <= req.position;
            s1_reg.end_position <= req.end_position;
            s1_reg.world_length <= req.world_length;
            s1_reg.frame_count  <= req.frame_count;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `SPR_ASSERT_NEXT(a_clamp_nonneg, fire && s1_reg.kind == KIND_CLAMP,
        !camera_reg[POS_W-1], "camera negative after clamp")
    `SPR_ASSERT_NEXT(a_flip_toggles, fire && s1_reg.kind == KIND_FLIP,
        back_page_reg != $past(back_page_reg) && rsp_valid_reg && rsp_reg.elapsed_frames != '0,
        "flip did not toggle page or reported zero frames")
    `SPR_ASSERT_NEXT(a_begin_resets, fire && s1_reg.kind == KIND_BEGIN,
        back_page_reg && camera_reg == '0 && drawn_end_reg[1] == '0,
        "begin did not reset tracking state")
    `SPR_ASSERT_NOW(a_fields_exclusive, rsp_valid_reg && rsp_reg.elapsed_frames != '0,
        !rsp_reg.need_draw && rsp_reg.span_from == '0 && rsp_reg.span_to == '0,
        "flip result carries query fields")

endmodule

/* tb/sv/spr_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// Scroll page redraw tracker scoreboard
// Predicts each result from the camera, frame and two-page drawn-span state
// and compares accepted results field by field, oldest expectation first.
// ----------------------------------------------------------------------------
package spr_scoreboard_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;

    class spr_scoreboard;
        logic [SPAN_W-1:0]  view_span;
        logic [SPAN_W-1:0]  page_span;
        int                 camera;
        bit                 back_page;
        logic [FRAME_W-1:0] prev_frame;
        int                 drawn_start [PAGE_COUNT];
        int                 drawn_end [PAGE_COUNT];
        rsp_t               expected_q [$];
        int unsigned        errors;
        int unsigned        requests;
        int unsigned        results;
        int unsigned        draws_needed;
        int unsigned        flips;
        int unsigned        trims;

        function new();
            view_span  = VIEW_SPAN_RESET;
            page_span  = PAGE_SPAN_RESET;
            camera     = 0;
            back_page  = 1'b1;
            prev_frame = '0;
            clear_pages();
        endfunction

        function void clear_pages();
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                drawn_start[i] = 0;
                drawn_end[i]   = 0;
            end
        endfunction

        function void write_config(logic [CFG_IDX_W-1:0] idx, logic [SPAN_W-1:0] data);
            if (idx == CFG_VIEW_SPAN)
                view_span = data;
            else if (idx == CFG_PAGE_SPAN)
                page_span = data;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(req_t r);
            rsp_t exp_rsp;
            int   lim;
            int   pos;
            int   wf;
            int   wt;
            int   ds;
            int   de;
            int   pg;
            exp_rsp = '0;
            pg = back_page;
            ds = drawn_start[pg];
            de = drawn_end[pg];
            requests++;
            case (r.kind)
                KIND_CLAMP:
                begin
                    lim = int'({1'b0, r.world_length}) - int'({16'd0, view_span});
                    if (lim < 0)
                        lim = 0;
                    pos = r.position;
                    if (pos < 0)
                        pos = 0;
                    if (lim < pos)
                        pos = lim;
                    camera = pos;
                end
                KIND_QUERY:
                begin
                    wf = camera;
                    wt = camera + int'({16'd0, view_span});
                    exp_rsp.need_draw = 1'b1;
                    if (!(ds < de))
                    begin
                        exp_rsp.span_from = wf;
                        exp_rsp.span_to   = wt;
                    end
                    else if (!(wf < ds) && !(de < wt))
                        exp_rsp.need_draw = 1'b0;
                    else if (!(wf < de) || !(ds < wt))
                    begin
                        exp_rsp.span_from = wf;
                        exp_rsp.span_to   = wt;
                    end
                    else if (de < wt)
                    begin
                        exp_rsp.span_from = de;
                        exp_rsp.span_to   = wt;
                    end
                    else
                    begin
                        exp_rsp.span_from = wf;
                        exp_rsp.span_to   = ds;
                    end
                    if (exp_rsp.need_draw)
                        draws_needed++;
                end
                KIND_MARK:
                begin
                    if (!(ds < de) || (de < r.position) || (r.end_position < ds))
                    begin
                        drawn_start[pg] = r.position;
                        drawn_end[pg]   = r.end_position;
                    end
                    else
                    begin
                        if (r.position < ds)
                            ds = r.position;
                        if (de < r.end_position)
                            de = r.end_position;
                        if (int'({16'd0, page_span}) < (de - ds))
                        begin
                            ds = de - int'({16'd0, page_span});
                            trims++;
                        end
                        drawn_start[pg] = ds;
                        drawn_end[pg]   = de;
                    end
                end
                KIND_FLIP:
                begin
                    exp_rsp.elapsed_frames = r.frame_count - prev_frame;
                    if (exp_rsp.elapsed_frames == '0)
                        exp_rsp.elapsed_frames = FRAME_W'(1);
                    prev_frame = r.frame_count;
                    back_page  = ~back_page;
                    flips++;
                end
                KIND_INVALIDATE:
                    clear_pages();
                KIND_BEGIN:
                begin
                    back_page  = 1'b1;
                    camera     = 0;
                    prev_frame = r.frame_count;
                    clear_pages();
                end
                default:
                    ;
            endcase
            expected_q.push_back(exp_rsp);
        endfunction

        function void compare_field(string name, logic [POS_W-1:0] exp_val,
                                    logic [POS_W-1:0] got_val);
            if (got_val !== exp_val)
            begin
                errors++;
                $display("%0t: %s expected %h, got %h", $time, name, exp_val, got_val);
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp_rsp;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, got %h", $time, got);
                return;
            end
            exp_rsp = expected_q.pop_front();
            results++;
            compare_field("need_draw", 32'(exp_rsp.need_draw), 32'(got.need_draw));
            compare_field("span_from", exp_rsp.span_from, got.span_from);
            compare_field("span_to", exp_rsp.span_to, got.span_to);
            compare_field("elapsed_frames", 32'(exp_rsp.elapsed_frames),
                          32'(got.elapsed_frames));
        endfunction
    endclass

endpackage

/* tb/sv/tb_scroll_page_redraw_tracker.sv */
// ----------------------------------------------------------------------------
// Scroll page redraw tracker testbench
// Directed commands over the camera, query, mark and flip corner cases, then
// random frame loops under several span settings with random idling on both
// channels, a long result stall and a full drain pause, all checked against
// a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_scroll_page_redraw_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;
    import spr_scoreboard_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int PHASES          = 7;
    localparam int PHASE_REQUESTS  = 200;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SPAN_W-1:0]     cfg_data;

    spr_req_if req_ch ();
    spr_rsp_if rsp_ch ();

    scroll_page_redraw_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    spr_scoreboard sb;

    bit                 idle_on;
    int unsigned        hold_requests;
    int unsigned        hold_served;
    int unsigned        hold_left;
    int unsigned        cycle_count;
    int                 aim;
    int                 world_size;
    logic [FRAME_W-1:0] frame_now;

    logic [SPAN_W-1:0] view_settings [PHASES] = '{16'd65535, 16'd1, 16'd0, 16'd16,
                                                  16'd200, 16'd320, 16'd65535};
    logic [SPAN_W-1:0] page_settings [PHASES] = '{16'd65535, 16'd1, 16'd0, 16'd100,
                                                  16'd400, 16'd640, 16'd1};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run exceeded %0d cycles with %0d results pending",
                     CYCLE_LIMIT, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        req_t took;
        rsp_t got;
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_config(cfg_index, cfg_data);
            if (req_ch.valid && req_ch.ready)
            begin
                took.kind         = req_ch.kind;
                took.position     = req_ch.position;
                took.end_position = req_ch.end_position;
                took.world_length = req_ch.world_length;
                took.frame_count  = req_ch.frame_count;
                sb.note_request(took);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.need_draw      = rsp_ch.need_draw;
                got.span_from      = rsp_ch.span_from;
                got.span_to        = rsp_ch.span_to;
                got.elapsed_frames = rsp_ch.elapsed_frames;
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            rsp_ch.ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end
        else
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 9);
    end

    function automatic req_t make_request(logic [KIND_W-1:0] kind, int pos, int end_pos,
                                          logic [WLEN_W-1:0] wlen, logic [FRAME_W-1:0] frame);
        req_t r;
        r.kind         = kind;
        r.position     = pos;
        r.end_position = end_pos;
        r.world_length = wlen;
        r.frame_count  = frame;
        return r;
    endfunction

    task automatic send_request(req_t r);
        while (idle_on && $urandom_range(99) < 9)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= r.kind;
        req_ch.position     <= r.position;
        req_ch.end_position <= r.end_position;
        req_ch.world_length <= r.world_length;
        req_ch.frame_count  <= r.frame_count;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_spans(logic [SPAN_W-1:0] view, logic [SPAN_W-1:0] page);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_VIEW_SPAN;
        cfg_data  <= view;
        @(posedge clk);
        cfg_index <= CFG_PAGE_SPAN;
        cfg_data  <= page;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // one command of a plausible scroll loop, with some random noise mixed in
    function automatic req_t random_request();
        req_t        r;
        int unsigned sel;
        int          start;
        r.kind         = KIND_QUERY;
        r.position     = $urandom;
        r.end_position = $urandom;
        r.world_length = WLEN_W'($urandom);
        r.frame_count  = FRAME_W'($urandom);
        sel = $urandom_range(99);
        aim = aim + int'($urandom_range(128)) - 64;
        if (aim < -200 || aim > world_size + 200)
            aim = world_size / 2;
        if (sel < 8)
            r.kind = KIND_W'($urandom);
        else if (sel < 30)
        begin
            r.kind     = KIND_CLAMP;
            r.position = aim;
            if ($urandom_range(19) != 0)
                r.world_length = WLEN_W'(world_size);
        end
        else if (sel < 55)
            r.kind = KIND_QUERY;
        else if (sel < 80)
        begin
            r.kind = KIND_MARK;
            start = aim + int'($urandom_range(1200)) - 600;
            r.position     = start;
            r.end_position = start + int'($urandom_range(800)) - 100;
        end
        else if (sel < 93)
        begin
            r.kind = KIND_FLIP;
            frame_now = frame_now + FRAME_W'($urandom_range(3));
            if ($urandom_range(19) == 0)
                frame_now = FRAME_W'($urandom);
            r.frame_count = frame_now;
        end
        else if (sel < 97)
            r.kind = KIND_INVALIDATE;
        else
        begin
            r.kind = KIND_BEGIN;
            frame_now = r.frame_count;
        end
        return r;
    endfunction

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_VIEW_SPAN;
        cfg_data      = '0;
        req_ch.valid  = 1'b0;
        req_ch.kind   = KIND_QUERY;
        req_ch.position     = '0;
        req_ch.end_position = '0;
        req_ch.world_length = '0;
        req_ch.frame_count  = '0;
        rsp_ch.ready  = 1'b0;
        idle_on       = 1'b1;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        cycle_count   = 0;
        aim           = 0;
        world_size    = 4000;
        frame_now     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_MARK, 0, 320, 0, 0));
        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_CLAMP, -5, 0, 1000, 0));
        send_request(make_request(KIND_CLAMP, 500, 0, 1000, 0));
        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_MARK, 320, 820, 0, 0));
        send_request(make_request(KIND_CLAMP, 100, 0, 1000, 0));
        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_CLAMP, 700, 0, 2000, 0));
        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_MARK, 5000, 6000, 0, 0));
        send_request(make_request(KIND_MARK, 32'h8000_0000, 32'h7fff_ffff, '1, '1));
        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_CLAMP, 50, 0, 100, 0));
        send_request(make_request(KIND_FLIP, 0, 0, 0, 16'h0000));
        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_FLIP, 0, 0, 0, 16'hffff));
        send_request(make_request(KIND_FLIP, 0, 0, 0, 16'h0002));
        send_request(make_request(KIND_INVALIDATE, 0, 0, 0, 0));
        send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
        send_request(make_request(KIND_SPARE_LO, -1, -1, '1, '1));
        send_request(make_request(KIND_SPARE_HI, 32'h8000_0000, 1, 1, 1));
        send_request(make_request(KIND_BEGIN, 0, 0, 0, 16'hffff));
        send_request(make_request(KIND_FLIP, 0, 0, 0, 16'h0000));
        send_request(make_request(KIND_CLAMP, 32'h7fff_ffff, 0, 31'h7fff_ffff, 0));
        frame_now = '0;
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_spans(view_settings[ph], page_settings[ph]);
            idle_on    = (ph != 2);
            world_size = $urandom_range(20000, 400);
            aim        = world_size / 2;
            if (ph == 0)
                send_request(make_request(KIND_QUERY, 0, 0, 0, 0));
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (ph == 3 && n == 50)
                    hold_requests = hold_requests + 1;
                if (ph == 4 && n == 100)
                    drain_results();
                send_request(random_request());
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("checked %0d results from %0d requests over %0d span settings",
                 sb.results, sb.requests, PHASES + 1);
        $display("%0d strips to draw, %0d span trims, %0d page flips",
                 sb.draws_needed, sb.trims, sb.flips);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
